>>> src/bpbuf_pkg.sv
`default_nettype none
package bpbuf_pkg;

	localparam int BUF_BYTES = 1024;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	// bit cursor must reach 8*BUF_BYTES inclusive
	localparam int CUR_W     = ADDR_W + 4;
	localparam int USED_W    = ADDR_W + 1;
	localparam int CFG_W     = 11;
	localparam int CMD_W     = 3;
	localparam int CNT_W     = 7;
	localparam int DATA_W    = 64;
	localparam int MAX_BITS  = 64;
	localparam int PHASE_W   = 4;
	localparam int LAST_PHASE = 9;
	localparam int CFG_RESET = 1024;

	localparam logic [CMD_W-1:0] CMD_WR_BITS = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RD_BITS = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_BYTE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_BYTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RST_WR  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RST_RD  = 3'd5;

	// control from sequencer to byte datapath
	typedef struct packed {
		logic                load;
		logic                run;
		logic                wr;
		logic [2:0]          bi;
		logic [CNT_W-1:0]    cnt;
		logic [PHASE_W-1:0]  nb;
		logic [ADDR_W-1:0]   base;
		logic [PHASE_W-1:0]  phase;
	} bpbuf_ctl_t;

	typedef struct packed {
		logic fin;
		logic ok;
	} bpbuf_sts_t;

	function automatic logic [7:0] lowmask8(input logic [2:0] n);
		lowmask8 = ~(8'hFF << n);
	endfunction

endpackage
`default_nettype wire

>>> src/bpbuf_ctrl.sv
`default_nettype none
module bpbuf_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [bpbuf_pkg::CMD_W-1:0] cmd,
	input  wire logic [bpbuf_pkg::CNT_W-1:0] bit_count,
	input  wire logic                      cfg_we,
	input  wire logic [bpbuf_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      out_free,
	output bpbuf_pkg::bpbuf_ctl_t          ctl,
	output bpbuf_pkg::bpbuf_sts_t          sts
);
	import bpbuf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DEC  = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	logic [CUR_W-1:0]   wcur_q, rcur_q;
	logic [CFG_W-1:0]   bb_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ok_q, wr_q;
	logic [2:0]         bi_q;
	logic [CNT_W-1:0]   ecnt_q;
	logic [PHASE_W-1:0] nb_q, phase_q;
	logic [ADDR_W-1:0]  base_q;

	logic               wr_op, byte_op, data_op, rst_op, cnt_bad, fit, ok_d;
	logic [CUR_W-1:0]   cur, cur_p7, eff, nxt;
	logic [CNT_W-1:0]   eff_cnt;
	logic [7:0]         span;
	logic [USED_W-1:0]  used;
	logic [USED_W:0]    reach;
	logic               accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		wr_op   = 1'b0;
		byte_op = 1'b0;
		data_op = 1'b0;
		rst_op  = 1'b0;
		case (cmd_q)
			CMD_WR_BITS: begin
				wr_op   = 1'b1;
				data_op = 1'b1;
			end
			CMD_RD_BITS: begin
				data_op = 1'b1;
			end
			CMD_WR_BYTE: begin
				wr_op   = 1'b1;
				byte_op = 1'b1;
				data_op = 1'b1;
			end
			CMD_RD_BYTE: begin
				byte_op = 1'b1;
				data_op = 1'b1;
			end
			CMD_RST_WR, CMD_RST_RD: begin
				rst_op = 1'b1;
			end
			default: begin
				rst_op = 1'b0;
			end
		endcase

		cur     = wr_op ? wcur_q : rcur_q;
		cur_p7  = cur + CUR_W'(7);
		// byte ops round up to the next byte boundary first
		eff     = byte_op ? {cur_p7[CUR_W-1:3], 3'b000} : cur;
		eff_cnt = byte_op ? CNT_W'(8) : cnt_q;
		cnt_bad = eff_cnt > CNT_W'(MAX_BITS);
		span    = 8'(eff[2:0]) + 8'(eff_cnt) + 8'd7;
		reach   = (USED_W+1)'(eff[CUR_W-1:3]) + (USED_W+1)'(span[7:3]);
		if (32'(bb_q) > 32'(BUF_BYTES)) begin
			used = USED_W'(BUF_BYTES);
		end else begin
			used = USED_W'(bb_q);
		end
		fit  = reach <= {1'b0, used};
		ok_d = data_op ? (fit && !cnt_bad) : rst_op;
		nxt  = ok_d ? eff + CUR_W'(eff_cnt) : eff;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			cnt_q <= bit_count;
		end
		if (state_q == ST_DEC) begin
			wr_q   <= wr_op;
			bi_q   <= eff[2:0];
			ecnt_q <= eff_cnt;
			nb_q   <= span[6:3];
			base_q <= eff[ADDR_W+2:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wcur_q  <= '0;
			rcur_q  <= '0;
			bb_q    <= CFG_W'(CFG_RESET);
			ok_q    <= 1'b0;
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				bb_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					ok_q    <= ok_d;
					phase_q <= '0;
					if (data_op) begin
						if (wr_op) begin
							wcur_q <= nxt;
						end else begin
							rcur_q <= nxt;
						end
					end
					if (cmd_q == CMD_RST_WR) begin
						wcur_q <= '0;
					end
					if (cmd_q == CMD_RST_RD) begin
						rcur_q <= '0;
					end
					state_q <= (data_op && ok_d) ? ST_RUN : ST_FIN;
				end
				ST_RUN: begin
					phase_q <= phase_q + PHASE_W'(1);
					if (phase_q == PHASE_W'(LAST_PHASE)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.load  = accept;
		ctl.run   = (state_q == ST_RUN);
		ctl.wr    = wr_q;
		ctl.bi    = bi_q;
		ctl.cnt   = ecnt_q;
		ctl.nb    = nb_q;
		ctl.base  = base_q;
		ctl.phase = phase_q;
		sts.fin   = (state_q == ST_FIN) && out_free;
		sts.ok    = ok_q;
	end

endmodule
`default_nettype wire

>>> src/bpbuf_dp.sv
`default_nettype none
module bpbuf_dp (
	input  wire logic                        clk,
	input  wire bpbuf_pkg::bpbuf_ctl_t       ctl,
	input  wire logic [bpbuf_pkg::DATA_W-1:0] data,
	output logic [bpbuf_pkg::DATA_W-1:0]     read_value
);
	import bpbuf_pkg::*;

	logic [7:0] mem [BUF_BYTES];

	logic [7:0]         rd_q, carry_q;
	logic [DATA_W-1:0]  dsr_q, res_q;
	logic [ADDR_W-1:0]  addr;
	logic [PHASE_W-1:0] k, off, e;
	logic               slot, in_span, we;
	logic [15:0]        ws, rs;
	logic [7:0]         keep_m, top_m, wbyte, rbyte, emit, cm, sw;

	// phase 0 fetches the first byte; slot k runs at phase k+1 with that byte's data
	always_comb begin
		k       = ctl.phase - PHASE_W'(1);
		e       = k - PHASE_W'(1);
		slot    = ctl.run && (ctl.phase != '0);
		in_span = k < ctl.nb;
		off     = (ctl.wr && slot) ? k : ctl.phase;
		addr    = ctl.base + ADDR_W'(off);
		we      = slot && ctl.wr && in_span;

		// write: next data byte shifted up by the bit offset, spill kept in carry
		ws     = 16'(dsr_q[7:0]) << ctl.bi;
		keep_m = lowmask8(ctl.bi);
		sw     = 8'(ctl.bi) + 8'(ctl.cnt);
		top_m  = (sw < 8'd8) ? lowmask8(sw[2:0]) : 8'hFF;
		if ((k == '0) && (ctl.bi != 3'd0)) begin
			wbyte = (rd_q & keep_m) | (ws[7:0] & top_m);
		end else begin
			wbyte = ws[7:0] | carry_q;
		end

		// read: stream byte shifted down by the bit offset
		rbyte = in_span ? rd_q : 8'h00;
		rs    = {rbyte, 8'h00} >> ctl.bi;
		if (e < PHASE_W'(ctl.cnt[6:3])) begin
			cm = 8'hFF;
		end else if (e == PHASE_W'(ctl.cnt[6:3])) begin
			cm = lowmask8(ctl.cnt[2:0]);
		end else begin
			cm = 8'h00;
		end
		emit = (carry_q | rs[7:0]) & cm;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wbyte;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dsr_q   <= data;
			res_q   <= '0;
			carry_q <= '0;
		end else if (slot) begin
			carry_q <= ctl.wr ? ws[15:8] : rs[15:8];
			if (ctl.wr) begin
				dsr_q <= {8'h00, dsr_q[DATA_W-1:8]};
			end else if (k != '0) begin
				res_q <= {emit, res_q[DATA_W-1:8]};
			end
		end
	end

	assign read_value = res_q;

endmodule
`default_nettype wire

>>> src/bit_packed_buffer_reader_writer.sv
// LSB-first bit stream buffer over a 1024-byte store, with a write cursor
// and a read cursor counting bits.
// Input channel s_*: one command per transfer (write/read 0..64 bits,
// align and write/read one byte, reset either cursor).
// Output channel m_*: one result per command: ok flag in m_tuser,
// value read in m_tdata (zero for failures and non-reads).
// cfg_we/cfg_wdata set the number of bytes in use (saturates at 1024);
// write only while no command is in flight.
// A data command that fits passes through decode, the ten-step byte
// sequencer and the hand-off state; one that fails, cursor resets and
// unused codes go from decode straight to the hand-off state.
// A new command is taken only after the last has handed off its result.
// The ten-step byte sequencer over the single-port byte memory moves one
// byte per cycle, up to nine bytes per command.
// A stalled receiver holds the result in the output register; the next
// command is still taken and runs, and waits only at its own hand-off.
// Reset clears both cursors, sets the size to 1024 and empties the
// output register; the store contents are undefined until written.
`default_nettype none
module bit_packed_buffer_reader_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // [6:0] bit_count, [70:7] data, [71] pad
	input  wire logic [2:0]  s_tuser,   // [2:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [63:0] read_value
	output logic [0:0]       m_tuser,   // [0] ok
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata
);
	import bpbuf_pkg::*;

	bpbuf_ctl_t        ctl;
	bpbuf_sts_t        sts;
	logic [DATA_W-1:0] value;
	logic              out_free;
	logic              m_tvalid_q, ok_q;
	logic [DATA_W-1:0] value_q;

	assign out_free = !m_tvalid_q || m_tready;

	bpbuf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cmd       (s_tuser[CMD_W-1:0]),
		.bit_count (s_tdata[CNT_W-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.ctl       (ctl),
		.sts       (sts)
	);

	bpbuf_dp u_dp (
		.clk        (clk),
		.ctl        (ctl),
		.data       (s_tdata[CNT_W+DATA_W-1:CNT_W]),
		.read_value (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (sts.fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.fin) begin
			ok_q    <= sts.ok;
			value_q <= value;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = value_q;
	assign m_tuser[0] = ok_q;

endmodule
`default_nettype wire
